[design/uvs_pkg.sv]
// ----------------------------------------------------------------------------
// uvs_pkg: shared types and constants of the unique value stack
// This package holds the payload types, the status and command codes, the
// cell control struct and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

   // default depth of the stack
   localparam int STACK_DEPTH_DEFAULT = 128;

   // match bits taken from the head of the cell row per scan cycle
   localparam int SCAN_WIDTH = 8;

   localparam int VALUE_W = 32;
   localparam int FILL_W  = 8;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [FILL_W-1:0]         fill_type;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_PUSHED    = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_POPPED    = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   // entry movement along the cell row
   typedef enum logic [1:0] {
      SH_HOLD = 2'd0,
      SH_DOWN = 2'd1,
      SH_UP   = 2'd2
   } shift_type;

   typedef struct packed {
      shift_type shift;
      logic      load_match;
      logic      shift_match;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_DECIDE = 2'd2
   } state_type;

endpackage

`default_nettype wire

[design/uvs_if.sv]
// ----------------------------------------------------------------------------
// uvs_if: request and response channels of the unique value stack
// Valid/ready channels carrying one operation or one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface uvs_req_if;
   logic                  valid;
   logic                  ready;
   uvs_pkg::command_type  command;
   uvs_pkg::value_type    push_value;

   modport source (output valid, output command, output push_value, input ready);
   modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface uvs_rsp_if;
   logic                  valid;
   logic                  ready;
   uvs_pkg::status_type   status;
   uvs_pkg::value_type    popped_value;
   uvs_pkg::fill_type     fill_level;

   modport source (output valid, output status, output popped_value, output fill_level,
                   input ready);
   modport sink   (input valid, input status, input popped_value, input fill_level,
                   output ready);
endinterface

`default_nettype wire

[design/unique_value_stack.sv]
// ----------------------------------------------------------------------------
// unique_value_stack: lifo stack of signed 32-bit values without duplicates
// A row of cells holds the stack with the top in cell 0. A push is checked
// against every held entry and rejected as duplicate or full; a pop returns
// the top entry or reports an empty stack.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                 transaction
//  req_bus   in         command, push_value                     one operation
//  rsp_bus   out        status, popped_value, fill_level        one result
//
//  a pop loads its result into the output register on acceptance
//  a push runs a compare step, a scan that walks the match bits up the cell
//  row eight cells per cycle, and a step to decide and insert
//  one operation is in flight at a time; the next is taken once the output
//  register is empty or hands off its result in that same cycle
//  synchronous active-high reset empties the stack at once; no clearing pass
//  a stalled response holds its register and blocks further acceptance
// ----------------------------------------------------------------------------
`default_nettype none

module unique_value_stack #(
   parameter int STACK_DEPTH = uvs_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   uvs_req_if.sink    req_bus,
   uvs_rsp_if.source  rsp_bus
);

   // count must hold the depth itself
   localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
   localparam int SW         = uvs_pkg::SCAN_WIDTH;
   localparam int GROUPS     = (STACK_DEPTH + SW - 1) / SW;
   localparam int SCAN_CNT_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   // control state
   uvs_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SCAN_CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic                  hit_ff, hit_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   uvs_pkg::value_type  value_ff, value_in;
   uvs_pkg::status_type rsp_status_ff, rsp_status_in;
   uvs_pkg::value_type  rsp_popped_ff, rsp_popped_in;
   uvs_pkg::fill_type   rsp_fill_ff;

   // cell row
   uvs_pkg::cell_ctl_type cell_ctl;
   uvs_pkg::value_type    entry_q [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] match_q;
   logic [STACK_DEPTH-1:0] cell_valid;
   logic [SW-1:0]          scan_bits;

   logic req_accept;
   logic rsp_load;
   logic scan_last;
   logic stack_empty;
   logic stack_full;

   assign req_accept  = req_bus.valid && req_bus.ready;
   assign scan_last   = (scan_cnt_ff == SCAN_CNT_W'(GROUPS - 1));
   assign stack_empty = (count_ff == '0);
   assign stack_full  = (count_ff == CNT_W'(STACK_DEPTH));

   // ---------------------------------------------------------------------
   // row of cells, top of stack in cell 0
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      uvs_pkg::value_type above;
      uvs_pkg::value_type below;
      logic               far;

      if (i == 0) begin : g_head
         assign above = value_ff;
      end else begin : g_body
         assign above = entry_q[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_tail
         assign below = '0;
      end else begin : g_inner
         assign below = entry_q[i+1];
      end

      // match bit comes from eight cells further down the row
      if (i + SW < STACK_DEPTH) begin : g_far
         assign far = match_q[i+SW];
      end else begin : g_far_end
         assign far = 1'b0;
      end

      assign cell_valid[i] = (CNT_W'(i) < count_ff);

      uvs_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .entry_valid (cell_valid[i]),
         .cmp_value   (req_bus.push_value),
         .above_value (above),
         .below_value (below),
         .match_far   (far),
         .entry       (entry_q[i]),
         .match       (match_q[i])
      );
   end

   // match bits arriving at the head of the row this scan cycle
   for (genvar j = 0; j < SW; j++) begin : g_scan
      if (j < STACK_DEPTH) begin : g_bit
         assign scan_bits[j] = match_q[j];
      end else begin : g_pad
         assign scan_bits[j] = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         uvs_pkg::S_IDLE: begin
            if (req_accept && (req_bus.command == uvs_pkg::CMD_PUSH)) begin
               state_in = uvs_pkg::S_SCAN;
            end
         end
         uvs_pkg::S_SCAN: begin
            if (scan_last) begin
               state_in = uvs_pkg::S_DECIDE;
            end
         end
         uvs_pkg::S_DECIDE: begin
            state_in = uvs_pkg::S_IDLE;
         end
         default: begin
            state_in = uvs_pkg::S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer: outputs and datapath control
   // ---------------------------------------------------------------------
   always_comb begin
      req_bus.ready        = 1'b0;
      cell_ctl.shift       = uvs_pkg::SH_HOLD;
      cell_ctl.load_match  = 1'b0;
      cell_ctl.shift_match = 1'b0;
      rsp_load             = 1'b0;
      rsp_status_in        = rsp_status_ff;
      rsp_popped_in        = rsp_popped_ff;
      count_in             = count_ff;
      scan_cnt_in          = scan_cnt_ff;
      hit_in               = hit_ff;
      value_in             = value_ff;

      case (state_ff)
         uvs_pkg::S_IDLE: begin
            // output register free or draining this cycle
            req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
            if (req_accept) begin
               if (req_bus.command == uvs_pkg::CMD_PUSH) begin
                  // every cell compares its entry with the pushed value
                  cell_ctl.load_match = 1'b1;
                  value_in            = req_bus.push_value;
                  scan_cnt_in         = '0;
                  hit_in              = 1'b0;
               end else begin
                  rsp_load = 1'b1;
                  if (stack_empty) begin
                     rsp_status_in = uvs_pkg::ST_EMPTY;
                     rsp_popped_in = '0;
                  end else begin
                     cell_ctl.shift = uvs_pkg::SH_UP;
                     rsp_status_in  = uvs_pkg::ST_POPPED;
                     rsp_popped_in  = entry_q[0];
                     count_in       = count_ff - CNT_W'(1);
                  end
               end
            end
         end
         uvs_pkg::S_SCAN: begin
            cell_ctl.shift_match = 1'b1;
            hit_in               = hit_ff || (|scan_bits);
            scan_cnt_in          = scan_cnt_ff + SCAN_CNT_W'(1);
         end
         uvs_pkg::S_DECIDE: begin
            rsp_load      = 1'b1;
            rsp_popped_in = '0;
            // duplicate check ranks above the capacity check
            if (hit_ff) begin
               rsp_status_in = uvs_pkg::ST_DUPLICATE;
            end else if (stack_full) begin
               rsp_status_in = uvs_pkg::ST_FULL;
            end else begin
               cell_ctl.shift = uvs_pkg::SH_DOWN;
               rsp_status_in  = uvs_pkg::ST_PUSHED;
               count_in       = count_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // response valid: set on load, cleared when taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uvs_pkg::S_IDLE;
         count_ff     <= '0;
         scan_cnt_ff  <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_cnt_ff  <= scan_cnt_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_popped_ff <= rsp_popped_in;
         // fill level carries the low bits of the count
         rsp_fill_ff   <= uvs_pkg::FILL_W'(count_in);
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.popped_value = rsp_popped_ff;
   assign rsp_bus.fill_level   = rsp_fill_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count above depth");

   a_scan_holds_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == uvs_pkg::S_SCAN) |=> $stable(count_ff))
      else $error("count changed during scan");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (rsp_status_in == uvs_pkg::ST_PUSHED))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not grow the stack by one");

   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && ((rsp_status_in == uvs_pkg::ST_DUPLICATE) ||
                    (rsp_status_in == uvs_pkg::ST_FULL) ||
                    (rsp_status_in == uvs_pkg::ST_EMPTY)))
      |=> $stable(count_ff))
      else $error("rejected operation changed the stack");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !rsp_load)
      else $error("pending response overwritten");

endmodule

`default_nettype wire

[design/uvs_cell.sv]
// ----------------------------------------------------------------------------
// uvs_cell: one storage cell of the stack row
// Holds one entry, shifts it to or from its neighbors, compares it with a
// pushed value and passes its match bit up the row during the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_cell (
   input  wire logic                   clock,
   input  wire uvs_pkg::cell_ctl_type  ctl,
   input  wire logic                   entry_valid,
   input  wire uvs_pkg::value_type     cmp_value,
   input  wire uvs_pkg::value_type     above_value,
   input  wire uvs_pkg::value_type     below_value,
   input  wire logic                   match_far,
   output      uvs_pkg::value_type     entry,
   output      logic                   match
);

   uvs_pkg::value_type entry_ff, entry_in;
   logic               match_ff, match_in;

   always_comb begin
      case (ctl.shift)
         uvs_pkg::SH_DOWN: entry_in = above_value;
         uvs_pkg::SH_UP:   entry_in = below_value;
         default:          entry_in = entry_ff;
      endcase
   end

   // match bit: loaded on compare, then walks toward the head of the row
   always_comb begin
      if (ctl.load_match) begin
         match_in = entry_valid && (entry_ff == cmp_value);
      end else if (ctl.shift_match) begin
         match_in = match_far;
      end else begin
         match_in = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

`default_nettype wire
